>>> sv/assert_macros.svh
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property on clk, off while rst_n is low.
`define CFB_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Condition that must never be seen at a clock edge.
`define CFB_NEVER(lbl, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

>>> sv/cfb_pkg.sv
package cfb_pkg;

    // Frame layout
    localparam int FRAME_BYTES = 64;
    localparam int KW          = $clog2(FRAME_BYTES);

    // CRC-8, MSB first, no reflection, no final xor
    localparam logic [7:0] CRC_POLY = 8'h07;
    localparam logic [7:0] CRC_MSB  = 8'h80;
    localparam logic [7:0] CRC_INIT = 8'h00;

    // Result status codes
    localparam logic [2:0] ST_TAKEN   = 3'd0;
    localparam logic [2:0] ST_QUEUED  = 3'd1;
    localparam logic [2:0] ST_DROPPED = 3'd2;
    localparam logic [2:0] ST_BYTE    = 3'd3;
    localparam logic [2:0] ST_EMPTY   = 3'd4;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CLOSE,
        S_DONE,
        S_POP_RD,
        S_POP_LD
    } state_t;

    // One byte through the CRC register
    function automatic logic [7:0] crc8_step(input logic [7:0] crc, input logic [7:0] b);
        logic [7:0] c;
        c = crc ^ b;
        for (int i = 0; i < 8; i++)
        begin
            c = ((c & CRC_MSB) != 8'h00) ? ((c << 1) ^ CRC_POLY) : (c << 1);
        end
        return c;
    endfunction

endpackage

>>> sv/cfb_ram.sv
// Simple dual-port RAM, one write and one registered read port.
module cfb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                                   clk,
    input  logic                                   we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                       wdata,
    input  logic                                   re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                       rdata
);

    logic [WIDTH-1:0] mem [0:DEPTH-1];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

>>> sv/crc8_frame_builder_fifo.sv
// Packs serial bytes (op 0) into 64-byte frames - length, data padded with
// zeros, a reserved zero byte, a sequence number and a CRC-8 (poly 0x07,
// init 0) over the first 63 bytes - and queues them in a QUEUE_DEPTH-frame
// FIFO held in one frame-store RAM; a pop request (op 1) plays the head frame
// out byte by byte. A data byte that leaves its chunk open is written to the
// gather buffer. For a byte that closes a chunk, the close sequencer walks
// all 64 frame bytes, one a cycle, through the CRC and, while the queue has
// room, into the frame store, then posts the queued/dropped result. A pop of
// a held frame reads each byte from the frame store, then loads it into the
// output register. A pop on an empty queue posts an empty result. Stalls on
// the output hold the sequencer. The RAMs need no clearing after reset;
// the block is ready at once.
`include "assert_macros.svh"

module crc8_frame_builder_fifo #(
    parameter int QUEUE_DEPTH = 16,
    parameter int MAX_DATA    = 60
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    output logic                             in_ready,
    input  logic                             op,
    input  logic [7:0]                       data_byte,
    input  logic                             chunk_end,
    output logic                             out_valid,
    input  logic                             out_ready,
    output logic [2:0]                       status,
    output logic [7:0]                       out_byte,
    output logic                             last,
    output logic [$clog2(QUEUE_DEPTH+1)-1:0] level
);

    localparam int KW  = cfb_pkg::KW;
    localparam int QW  = $clog2(QUEUE_DEPTH);
    localparam int LW  = $clog2(QUEUE_DEPTH + 1);
    localparam int CW  = $clog2(MAX_DATA + 1);
    localparam int GW  = (MAX_DATA > 1) ? $clog2(MAX_DATA) : 1;
    localparam int FAW = QW + KW;

    localparam logic [KW-1:0] K_LAST = KW'(cfb_pkg::FRAME_BYTES - 1);
    localparam logic [KW-1:0] K_SEQ  = KW'(cfb_pkg::FRAME_BYTES - 2);
    localparam logic [LW-1:0] L_FULL = LW'(QUEUE_DEPTH);

    function automatic logic [QW-1:0] slot_inc(input logic [QW-1:0] s);
        return (s == QW'(QUEUE_DEPTH - 1)) ? '0 : QW'(s + QW'(1));
    endfunction

    // Control state
    cfb_pkg::state_t state_reg, state_next;
    logic [QW-1:0]   rslot_reg, rslot_next;
    logic [QW-1:0]   wslot_reg, wslot_next;
    logic [LW-1:0]   fill_reg, fill_next;
    logic [7:0]      seq_reg, seq_next;
    logic [CW-1:0]   cnt_reg, cnt_next;
    logic [KW-1:0]   k_reg, k_next;
    logic            out_valid_reg, out_valid_next;

    // Working payload
    logic [CW-1:0]   len_reg, len_next;
    logic [7:0]      crc_reg, crc_next;
    logic [QW-1:0]   cur_slot_reg, cur_slot_next;
    logic [2:0]      out_status_reg, out_status_next;
    logic [7:0]      out_byte_reg, out_byte_next;
    logic            out_last_reg, out_last_next;
    logic [LW-1:0]   out_level_reg, out_level_next;

    logic            out_free;
    logic            accept;
    logic            out_load;
    logic [CW-1:0]   cnt_plus;
    logic [7:0]      byte_val;
    logic            full;

    logic            gram_we, gram_re;
    logic [7:0]      gram_rdata;
    logic            fram_we, fram_re;
    logic [7:0]      fram_rdata;

    // Gather buffer for the open chunk
    cfb_ram #(
        .WIDTH (8),
        .DEPTH (MAX_DATA)
    ) u_gather (
        .clk   (clk),
        .we    (gram_we),
        .waddr (cnt_reg[GW-1:0]),
        .wdata (data_byte),
        .re    (gram_re),
        .raddr (k_reg[GW-1:0]),
        .rdata (gram_rdata)
    );

    // Frame store: one row of FRAME_BYTES per queue slot
    cfb_ram #(
        .WIDTH (8),
        .DEPTH (QUEUE_DEPTH * cfb_pkg::FRAME_BYTES)
    ) u_frames (
        .clk   (clk),
        .we    (fram_we),
        .waddr (FAW'({wslot_reg, k_reg})),
        .wdata (byte_val),
        .re    (fram_re),
        .raddr (FAW'({cur_slot_reg, k_reg})),
        .rdata (fram_rdata)
    );

    assign out_free = !out_valid_reg || out_ready;
    assign in_ready = (state_reg == cfb_pkg::S_IDLE) && out_free;
    assign accept   = in_valid && in_ready;
    assign cnt_plus = CW'(cnt_reg + CW'(1));
    assign full     = (fill_reg == L_FULL);

    // Frame byte at position k during a close
    always_comb
    begin
        priority if (k_reg == '0)
            byte_val = 8'(len_reg);
        else if (k_reg == K_SEQ)
            byte_val = seq_reg;
        else if (k_reg == K_LAST)
            byte_val = crc_reg;
        else if (k_reg <= KW'(len_reg))
            byte_val = gram_rdata;
        else
            byte_val = 8'h00;
    end

    // Sequencer
    always_comb
    begin
        state_next      = state_reg;
        rslot_next      = rslot_reg;
        wslot_next      = wslot_reg;
        fill_next       = fill_reg;
        seq_next        = seq_reg;
        cnt_next        = cnt_reg;
        k_next          = k_reg;
        len_next        = len_reg;
        crc_next        = crc_reg;
        cur_slot_next   = cur_slot_reg;
        out_load        = 1'b0;
        out_status_next = out_status_reg;
        out_byte_next   = 8'h00;
        out_last_next   = 1'b1;
        out_level_next  = fill_reg;
        gram_we         = 1'b0;
        gram_re         = 1'b0;
        fram_we         = 1'b0;
        fram_re         = 1'b0;

        unique case (state_reg)
            cfb_pkg::S_IDLE:
            begin
                if (accept)
                begin
                    if (!op)
                    begin
                        gram_we = 1'b1;
                        if (chunk_end || (cnt_plus == CW'(MAX_DATA)))
                        begin
                            len_next   = cnt_plus;
                            cnt_next   = '0;
                            k_next     = '0;
                            crc_next   = cfb_pkg::CRC_INIT;
                            state_next = cfb_pkg::S_CLOSE;
                        end
                        else
                        begin
                            cnt_next        = cnt_plus;
                            out_load        = 1'b1;
                            out_status_next = cfb_pkg::ST_TAKEN;
                        end
                    end
                    else if (fill_reg == '0)
                    begin
                        out_load        = 1'b1;
                        out_status_next = cfb_pkg::ST_EMPTY;
                    end
                    else
                    begin
                        cur_slot_next = rslot_reg;
                        rslot_next    = slot_inc(rslot_reg);
                        fill_next     = LW'(fill_reg - LW'(1));
                        k_next        = '0;
                        state_next    = cfb_pkg::S_POP_RD;
                    end
                end
            end

            cfb_pkg::S_CLOSE:
            begin
                // read data byte k+1 ahead, fold byte k into the CRC
                gram_re  = (k_reg < KW'(len_reg));
                fram_we  = !full;
                crc_next = cfb_pkg::crc8_step(crc_reg, byte_val);
                if (k_reg == K_LAST)
                    state_next = cfb_pkg::S_DONE;
                else
                    k_next = KW'(k_reg + KW'(1));
            end

            cfb_pkg::S_DONE:
            begin
                if (out_free)
                begin
                    out_load = 1'b1;
                    seq_next = 8'(seq_reg + 8'd1);
                    if (full)
                    begin
                        out_status_next = cfb_pkg::ST_DROPPED;
                    end
                    else
                    begin
                        out_status_next = cfb_pkg::ST_QUEUED;
                        fill_next       = LW'(fill_reg + LW'(1));
                        wslot_next      = slot_inc(wslot_reg);
                        out_level_next  = LW'(fill_reg + LW'(1));
                    end
                    state_next = cfb_pkg::S_IDLE;
                end
            end

            cfb_pkg::S_POP_RD:
            begin
                fram_re    = 1'b1;
                state_next = cfb_pkg::S_POP_LD;
            end

            cfb_pkg::S_POP_LD:
            begin
                if (out_free)
                begin
                    out_load        = 1'b1;
                    out_status_next = cfb_pkg::ST_BYTE;
                    out_byte_next   = fram_rdata;
                    out_last_next   = (k_reg == K_LAST);
                    if (k_reg == K_LAST)
                    begin
                        state_next = cfb_pkg::S_IDLE;
                    end
                    else
                    begin
                        k_next     = KW'(k_reg + KW'(1));
                        state_next = cfb_pkg::S_POP_RD;
                    end
                end
            end

            default:
            begin
                state_next = cfb_pkg::S_IDLE;
            end
        endcase

        if (out_load)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= cfb_pkg::S_IDLE;
            rslot_reg     <= '0;
            wslot_reg     <= '0;
            fill_reg      <= '0;
            seq_reg       <= '0;
            cnt_reg       <= '0;
            k_reg         <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rslot_reg     <= rslot_next;
            wslot_reg     <= wslot_next;
            fill_reg      <= fill_next;
            seq_reg       <= seq_next;
            cnt_reg       <= cnt_next;
            k_reg         <= k_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        len_reg      <= len_next;
        crc_reg      <= crc_next;
        cur_slot_reg <= cur_slot_next;
        if (out_load)
        begin
            out_status_reg <= out_status_next;
            out_byte_reg   <= out_byte_next;
            out_last_reg   <= out_last_next;
            out_level_reg  <= out_level_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign status    = out_status_reg;
    assign out_byte  = out_byte_reg;
    assign last      = out_last_reg;
    assign level     = out_level_reg;

    // Checks
    `CFB_NEVER(a_fill_bound, fill_reg > L_FULL, "queue fill above depth")
    `CFB_ASSERT(a_store_write, fram_we |-> (state_reg == cfb_pkg::S_CLOSE) && !full,
                "frame store written outside close or while full")
    `CFB_ASSERT(a_empty_level,
                (out_valid_reg && (out_status_reg == cfb_pkg::ST_EMPTY)) |-> (out_level_reg == '0),
                "empty status with frames held")
    `CFB_ASSERT(a_byte_zero,
                (out_valid_reg && (out_status_reg != cfb_pkg::ST_BYTE)) |-> (out_byte_reg == 8'h00),
                "nonzero byte on a status result")
    `CFB_ASSERT(a_seq_step,
                ((state_reg == cfb_pkg::S_DONE) && out_free) |=> (seq_reg == 8'($past(seq_reg) + 8'd1)),
                "sequence did not advance on close")

endmodule

>>> tb/sv/tb_top.sv
`timescale 1ns / 100ps

module tb_top;

    localparam int DEPTH    = 16;
    localparam int MAXD     = 60;
    localparam int LW       = $clog2(DEPTH + 1);
    localparam int SETTLE   = 200;
    localparam int MIN_REQS = 270;

    // One request on the input channel
    typedef struct packed {
        logic       op;
        logic [7:0] data;
        logic       fin;
    } req_t;

    // One beat on the output channel
    typedef struct packed {
        logic [2:0]    status;
        logic [7:0]    data;
        logic          last;
        logic [LW-1:0] level;
    } beat_t;

    logic          clk       = 1'b0;
    logic          rst_n     = 1'b0;
    logic          in_valid  = 1'b0;
    logic          in_ready;
    logic          op        = 1'b0;
    logic [7:0]    data_byte = 8'h00;
    logic          chunk_end = 1'b0;
    logic          out_valid;
    logic          out_ready = 1'b0;
    logic [2:0]    status;
    logic [7:0]    out_byte;
    logic          last;
    logic [LW-1:0] level;

    // Stimulus and expected beats
    req_t  req_q[$];
    beat_t beat_q[$];
    int    offered_cnt  = 0;
    int    accepted_cnt = 0;
    int    err_cnt      = 0;

    // Generator bookkeeping (requests queued so far)
    int gen_reqs   = 0;

    // Shadow of the framer and its frame queue
    logic [7:0] slot_mem [DEPTH][cfb_pkg::FRAME_BYTES];
    logic [7:0] gather_buf [MAXD];
    int         gathered = 0;
    int         held     = 0;
    int         wr_slot  = 0;
    int         rd_slot  = 0;
    logic [7:0] seq_num  = 8'h00;

    // Idle control
    int in_gap    = 0;
    int out_gap   = 0;
    bit in_quiet  = 1'b0;
    bit out_quiet = 1'b0;

    crc8_frame_builder_fifo #(
        .QUEUE_DEPTH (DEPTH),
        .MAX_DATA    (MAXD)
    ) i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .op        (op),
        .data_byte (data_byte),
        .chunk_end (chunk_end),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .status    (status),
        .out_byte  (out_byte),
        .last      (last),
        .level     (level)
    );

    // CRC-8 poly 0x07, bit-serial, MSB first
    function automatic logic [7:0] crc_update(input logic [7:0] crc, input logic [7:0] b);
        logic [7:0] c;
        logic       fb;
        c = crc;
        for (int i = 7; i >= 0; i--)
        begin
            fb = c[7] ^ b[i];
            c  = {c[6:0], 1'b0} ^ (fb ? cfb_pkg::CRC_POLY : 8'h00);
        end
        return c;
    endfunction

    // Mostly short gaps, a few long ones, none in quiet stretches
    function automatic int pick_gap(input bit quiet);
        int r;
        r = $urandom_range(0, 99);
        if (quiet || r < 65)
            return 0;
        else if (r < 94)
            return $urandom_range(1, 3);
        else
            return $urandom_range(8, 30);
    endfunction

    task automatic report_err(input string msg);
        $display("ERROR @%0t: %s", $time, msg);
        err_cnt++;
    endtask

    // Expected beats for one accepted request
    task automatic framer_step(input logic rq_op, input logic [7:0] rq_data,
                               input logic rq_fin);
        logic [7:0] frm [cfb_pkg::FRAME_BYTES];
        logic [7:0] crc;
        logic [2:0] st;
        int         s;
        if (rq_op == 1'b0)
        begin
            if (gathered < MAXD)
                gather_buf[gathered] = rq_data;
            gathered++;
            if (rq_fin || gathered >= MAXD)
            begin
                // build the frame: length, data, pad, reserved, sequence, crc
                for (int i = 0; i < cfb_pkg::FRAME_BYTES; i++)
                    frm[i] = 8'h00;
                frm[0] = 8'(gathered);
                for (int i = 0; i < gathered && i < MAXD; i++)
                    frm[1 + i] = gather_buf[i];
                frm[cfb_pkg::FRAME_BYTES - 2] = seq_num;
                crc = cfb_pkg::CRC_INIT;
                for (int i = 0; i < cfb_pkg::FRAME_BYTES - 1; i++)
                    crc = crc_update(crc, frm[i]);
                frm[cfb_pkg::FRAME_BYTES - 1] = crc;
                if (held >= DEPTH)
                    st = cfb_pkg::ST_DROPPED;
                else
                begin
                    for (int i = 0; i < cfb_pkg::FRAME_BYTES; i++)
                        slot_mem[wr_slot][i] = frm[i];
                    wr_slot = (wr_slot + 1) % DEPTH;
                    held++;
                    st = cfb_pkg::ST_QUEUED;
                end
                seq_num++;
                gathered = 0;
            end
            else
                st = cfb_pkg::ST_TAKEN;
            beat_q.push_back('{st, 8'h00, 1'b1, LW'(held)});
        end
        else if (held == 0)
            beat_q.push_back('{cfb_pkg::ST_EMPTY, 8'h00, 1'b1, LW'(0)});
        else
        begin
            // pop: head frame, byte by byte
            s = rd_slot;
            rd_slot = (rd_slot + 1) % DEPTH;
            held--;
            for (int k = 0; k < cfb_pkg::FRAME_BYTES; k++)
                beat_q.push_back('{cfb_pkg::ST_BYTE, slot_mem[s][k],
                                   k == cfb_pkg::FRAME_BYTES - 1, LW'(held)});
        end
    endtask

    // Generator helpers
    task automatic push_req(input logic rq_op, input logic [7:0] rq_data,
                            input logic rq_fin);
        req_q.push_back('{rq_op, rq_data, rq_fin});
        gen_reqs++;
    endtask

    // len data bytes; chunk_end on the final one if use_end
    task automatic add_chunk(input int len, input bit use_end);
        for (int i = 0; i < len; i++)
            push_req(1'b0, 8'($urandom), use_end && (i == len - 1));
    endtask

    // Pops carry random values in the ignored fields
    task automatic add_pops(input int n);
        for (int i = 0; i < n; i++)
            push_req(1'b1, 8'($urandom), 1'($urandom));
    endtask

    // Clock
    initial
    begin
        forever #10 clk = ~clk;
    end

    // Timeout
    initial
    begin
        #100_000_000;
        $display("** crc8_frame_builder_fifo: FAILED **");
        $finish;
    end

    // Request driver
    always @(negedge clk)
    begin
        if (!rst_n)
            in_valid <= 1'b0;
        else if (accepted_cnt == offered_cnt)
        begin
            if ($urandom_range(0, 63) == 0)
                in_quiet = ~in_quiet;
            if (in_gap > 0)
            begin
                in_gap--;
                in_valid <= 1'b0;
            end
            else if (req_q.size() > 0)
            begin
                req_t r;
                r = req_q.pop_front();
                op        <= r.op;
                data_byte <= r.data;
                chunk_end <= r.fin;
                in_valid  <= 1'b1;
                offered_cnt++;
                in_gap = pick_gap(in_quiet);
            end
            else
                in_valid <= 1'b0;
        end
    end

    // Output back-pressure
    always @(negedge clk)
    begin
        if ($urandom_range(0, 63) == 0)
            out_quiet = ~out_quiet;
        if (!rst_n)
            out_ready <= 1'b0;
        else if (out_gap > 0)
        begin
            out_gap--;
            out_ready <= 1'b0;
        end
        else
        begin
            out_ready <= 1'b1;
            out_gap = pick_gap(out_quiet);
        end
    end

    // Monitor: predict on accepted requests, check accepted beats
    always @(posedge clk)
    begin
        beat_t e;
        if (rst_n)
        begin
            if (in_valid && in_ready)
            begin
                framer_step(op, data_byte, chunk_end);
                accepted_cnt++;
            end
            if (out_valid && out_ready)
            begin
                if (beat_q.size() == 0)
                    report_err($sformatf(
                        "unexpected beat status=%0d byte=%02h last=%0b level=%0d",
                        status, out_byte, last, level));
                else
                begin
                    e = beat_q.pop_front();
                    if (status !== e.status || out_byte !== e.data ||
                        last !== e.last || level !== e.level)
                        report_err($sformatf(
                            {"beat got st=%0d byte=%02h last=%0b lvl=%0d",
                             " exp st=%0d byte=%02h last=%0b lvl=%0d"},
                            status, out_byte, last, level,
                            e.status, e.data, e.last, e.level));
                end
            end
        end
    end

    // Stimulus, reset and end of run
    initial
    begin
        int sel;
        // directed: empty pops, extreme bytes, pop mid-chunk, short frames
        push_req(1'b1, 8'hFF, 1'b1);
        push_req(1'b1, 8'h00, 1'b0);
        push_req(1'b0, 8'h00, 1'b1);
        push_req(1'b0, 8'hFF, 1'b0);
        push_req(1'b0, 8'h80, 1'b0);
        push_req(1'b1, 8'h55, 1'b0);
        push_req(1'b0, 8'h7F, 1'b1);
        push_req(1'b1, 8'hAA, 1'b1);
        push_req(1'b1, 8'h00, 1'b0);
        push_req(1'b0, 8'h01, 1'b1);
        push_req(1'b0, 8'hFE, 1'b1);
        push_req(1'b1, 8'h0F, 1'b0);
        push_req(1'b1, 8'hF0, 1'b1);
        push_req(1'b1, 8'h3C, 1'b0);

        // full-length chunk with end mark, then one closed early at 60
        add_chunk(MAXD, 1'b1);
        add_chunk(MAXD + 5, 1'b1);
        add_pops(3);

        // random scenarios; bursts of closes fill the queue
        while (gen_reqs < MIN_REQS)
        begin
            sel = $urandom_range(0, 9);
            case (sel)
                0, 1:
                    add_chunk($urandom_range(1, 8), 1'b1);
                2:
                    add_chunk($urandom_range(40, 70), 1'($urandom));
                3, 4:
                    add_pops($urandom_range(1, 3));
                5:
                begin
                    // noise: mixed requests, pops inside open chunks
                    repeat ($urandom_range(1, 10))
                        push_req($urandom_range(0, 3) == 0, 8'($urandom),
                                 $urandom_range(0, 7) == 0);
                end
                6, 7:
                    add_chunk(1, 1'b1) ;
                8:
                    add_pops($urandom_range(8, 17));
                default:
                begin
                    add_chunk($urandom_range(1, 4), 1'b1);
                    add_pops(1);
                end
            endcase
            // burst of single-byte frames
            if (sel == 6 || sel == 7)
                repeat ($urandom_range(30, 60))
                    add_chunk(1, 1'b1);
        end
        add_pops(DEPTH + 1);

        // hold reset, then release it on a falling edge
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // drain
        while (req_q.size() != 0 || accepted_cnt != offered_cnt)
            @(posedge clk);
        while (beat_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);

        if (err_cnt == 0 && beat_q.size() == 0)
            $display("** crc8_frame_builder_fifo: PASSED **");
        else
            $display("** crc8_frame_builder_fifo: FAILED **");
        $finish;
    end

endmodule
